/* rtl/bspe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// B-spline point evaluator package
// Shared constants, payload structs, controller commands and status.
// ----------------------------------------------------------------------------
package bspe_pkg;

   // Sizes of the control point store and the spline degree.
   localparam int MAX_POINTS = 64;
   localparam int PT_AW      = $clog2(MAX_POINTS);
   localparam int MAX_DEGREE = 7;
   localparam int DEG_W      = 3;
   localparam int CNT_W      = 7;

   // Basis values are unsigned Q.27, so 1.0 needs 28 bits.
   localparam int BASIS_FRAC = 27;
   localparam int BASIS_W    = BASIS_FRAC + 1;

   // Knot arithmetic width (signed), long division widths.
   localparam int KW     = 10;
   localparam int DIV_W  = 40;
   localparam int PROD_W = 53;

   // Configuration register port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMPED = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT   = 2'd2;

   // Request opcodes.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   typedef struct packed {
      logic               opcode;
      logic [5:0]         point_index;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic signed [31:0] coord_z;
      logic signed [23:0] param_t;
   } bspe_req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               too_few_points;
   } bspe_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_DIV_LOAD,
      ST_DIV_WAIT,
      ST_SUM_READ,
      ST_SUM_MUL,
      ST_SUM_ACC,
      ST_DONE
   } bspe_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic             write_point;
      logic             load_t;
      logic             setup;
      logic             mul;
      logic             div_start;
      logic             take;
      logic             sum_read;
      logic             sum_mul;
      logic             sum_acc;
      logic [DEG_W-1:0] k;
      logic [DEG_W-1:0] j;
      logic             term;
   } bspe_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic too_few;
      logic span_ok;
      logic div_done;
   } bspe_status_type;

endpackage
`default_nettype wire

/* rtl/bspe_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Small-divisor long divider
// Divides a 40-bit unsigned value by a 3-bit divisor, eight bits a cycle.
// ----------------------------------------------------------------------------
module bspe_div import bspe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   input  logic [2:0]       divisor,
   output logic             done,
   output logic [DIV_W-1:0] quotient
);

   localparam int STEPS = 8;
   localparam int PASSES = DIV_W / STEPS;
   localparam int CW = $clog2(PASSES);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [DIV_W-1:0] dq_ff, dq_in;
   logic [2:0]       rem_ff, rem_in;
   logic [2:0]       den_ff, den_in;

   // Eight restoring division steps per cycle on a narrow remainder.
   always_comb begin
      logic [3:0]       r;
      logic [DIV_W-1:0] q;
      r = {1'b0, rem_ff};
      q = dq_ff;
      for (int s = 0; s < STEPS; s++) begin
         r = {r[2:0], q[DIV_W-1]};
         q = {q[DIV_W-2:0], 1'b0};
         if (r >= {1'b0, den_ff}) begin
            r    = r - {1'b0, den_ff};
            q[0] = 1'b1;
         end
      end
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dq_in   = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         dq_in  = q;
         rem_in = r[2:0];
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(PASSES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = dq_ff;

endmodule
`default_nettype wire

/* rtl/bspe_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// B-spline evaluator datapath
// Control point memory, knot and basis arithmetic, divider and accumulators.
// ----------------------------------------------------------------------------
module bspe_dp import bspe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  bspe_cmd_type     cmd,
   input  logic [DEG_W-1:0] degree,
   input  logic             clamped,
   input  logic [CNT_W-1:0] count_eff,
   input  bspe_req_type     req_item,
   output bspe_status_type  status,
   output bspe_rsp_type     rsp_item
);

   localparam logic [BASIS_W-1:0] BASIS_ONE = BASIS_W'(1) << BASIS_FRAC;

   // Knot value j - degree, limited to 0 .. n - degree for clamped knots.
   function automatic logic signed [KW-1:0] knot_lim(
      input logic signed [KW-1:0] v,
      input logic                 cl,
      input logic signed [KW-1:0] hi
   );
      logic signed [KW-1:0] r;
      r = v;
      if (cl) begin
         if (r < 0) r = '0;
         if (r > hi) r = hi;
      end
      return r;
   endfunction

   // Control point memory, {x, y, z} per slot.
   logic [95:0] cp_mem [MAX_POINTS];
   logic [95:0] rd_ff;

   logic signed [23:0]         t_ff;
   logic [BASIS_W-1:0]         w_ff [MAX_DEGREE + 1];
   logic [PROD_W-1:0]          p_ff;
   logic [2:0]                 den_ff;
   logic [DIV_W-1:0]           part_ff;
   logic                       too_few_ff;
   logic                       tap_ok_ff;
   logic [BASIS_W-1:0]         tap_w_ff;
   logic signed [60:0]         prod_ff [3];
   logic signed [63:0]         acc_ff  [3];

   logic signed [KW-1:0] ti_s, d_s, n_s, k_s, j_s, hi_lim;
   logic signed [KW-1:0] base_s, a_lo, a_hi, kl_s, kh_s, den_s, idx_s;
   logic signed [26:0]   t27, kl27, kh27, num_s;
   logic                 num_pos, den_ok, tap_ok;
   logic [DEG_W:0]       b_idx;
   logic [BASIS_W-1:0]   b_val;
   logic [53:0]          x_sum;
   logic [DIV_W-1:0]     div_q;
   logic                 div_done;
   logic [DIV_W:0]       w_sum;
   logic [BASIS_W-1:0]   w_new;
   logic signed [31:0]   lane_in [3];
   logic signed [31:0]   lane_out [3];

   // Knot indexes of the current term.
   always_comb begin
      ti_s   = $signed({{(KW-8){t_ff[23]}}, t_ff[23:16]});
      d_s    = $signed({{(KW-DEG_W){1'b0}}, degree});
      n_s    = $signed({{(KW-CNT_W){1'b0}}, count_eff});
      k_s    = $signed({{(KW-DEG_W){1'b0}}, cmd.k});
      j_s    = $signed({{(KW-DEG_W){1'b0}}, cmd.j});
      hi_lim = n_s - d_s;
      base_s = ti_s + j_s - d_s;
      a_lo   = base_s + $signed({{(KW-1){1'b0}}, cmd.term});
      a_hi   = a_lo + k_s;
      kl_s   = knot_lim(a_lo, clamped, hi_lim);
      kh_s   = knot_lim(a_hi, clamped, hi_lim);
      den_s  = kh_s - kl_s;
      idx_s  = ti_s + j_s;
   end

   // Distance from t to the relevant knot, in Q16.
   always_comb begin
      t27     = $signed({{3{t_ff[23]}}, t_ff});
      kl27    = $signed({kl_s[KW-1], kl_s, 16'b0});
      kh27    = $signed({kh_s[KW-1], kh_s, 16'b0});
      num_s   = cmd.term ? (kh27 - t27) : (t27 - kl27);
      num_pos = !num_s[26] && (num_s != '0);
      den_ok  = (den_s != '0);
   end

   // Single read port into the basis window.
   always_comb begin
      b_idx = {1'b0, cmd.j} + {{DEG_W{1'b0}}, cmd.term};
      if (b_idx > {1'b0, degree}) begin
         b_val = '0;
      end else begin
         b_val = w_ff[b_idx[DEG_W-1:0]];
      end
   end

   // Rounded dividend: (num * N + den * 2^15) / 2^16.
   assign x_sum = {1'b0, p_ff} + {36'b0, den_ff, 15'b0};

   bspe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend ({2'b0, x_sum[53:16]}),
      .divisor  (den_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   // Sum of the two terms, limited to 1.0.
   always_comb begin
      w_sum = {1'b0, part_ff} + {1'b0, div_q};
      if (w_sum > (DIV_W + 1)'(BASIS_ONE)) begin
         w_new = BASIS_ONE;
      end else begin
         w_new = w_sum[BASIS_W-1:0];
      end
   end

   assign tap_ok = !idx_s[KW-1] && (idx_s < n_s) && (b_val != '0);

   // Status toward the controller.
   always_comb begin
      status.too_few  = (count_eff < ({{(CNT_W-DEG_W){1'b0}}, degree} + CNT_W'(1)));
      if (clamped) begin
         status.span_ok = (ti_s >= 0) && (ti_s < hi_lim);
      end else begin
         status.span_ok = (ti_s >= -d_s) && (ti_s < n_s);
      end
      status.div_done = div_done;
   end

   // Control point memory: write on request, registered read.
   always_ff @(posedge clock) begin
      if (cmd.write_point) begin
         cp_mem[req_item.point_index[PT_AW-1:0]] <=
            {req_item.coord_x, req_item.coord_y, req_item.coord_z};
      end
      if (cmd.sum_read) begin
         rd_ff <= cp_mem[idx_s[PT_AW-1:0]];
      end
   end

   assign lane_in[0] = $signed(rd_ff[95:64]);
   assign lane_in[1] = $signed(rd_ff[63:32]);
   assign lane_in[2] = $signed(rd_ff[31:0]);

   // Basis triangle and accumulation registers.
   always_ff @(posedge clock) begin
      if (cmd.load_t) begin
         t_ff <= req_item.param_t;
      end
      if (cmd.setup) begin
         // Level zero: only the span that holds t starts at 1.0.
         for (int e = 0; e <= MAX_DEGREE; e++) begin
            w_ff[e] <= (DEG_W'(e) == degree) ? BASIS_ONE : '0;
         end
         too_few_ff   <= status.too_few;
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= '0;
         end
      end
      if (cmd.mul) begin
         p_ff   <= (num_pos && den_ok) ? PROD_W'(num_s[24:0]) * PROD_W'(b_val) : '0;
         den_ff <= den_ok ? den_s[2:0] : 3'd1;
      end
      if (cmd.take) begin
         if (!cmd.term) begin
            part_ff <= div_q;
         end else begin
            w_ff[cmd.j] <= w_new;
         end
      end
      if (cmd.sum_read) begin
         tap_ok_ff <= tap_ok;
         tap_w_ff  <= b_val;
      end
      if (cmd.sum_mul) begin
         for (int c = 0; c < 3; c++) begin
            prod_ff[c] <= tap_ok_ff ? $signed({1'b0, tap_w_ff}) * lane_in[c] : 61'sd0;
         end
      end
      if (cmd.sum_acc) begin
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= acc_ff[c] + $signed({{3{prod_ff[c][60]}}, prod_ff[c]});
         end
      end
   end

   // Round half up to Q16.16 and saturate.
   always_comb begin
      logic signed [63:0] v;
      logic signed [36:0] r;
      for (int c = 0; c < 3; c++) begin
         v = acc_ff[c] + (64'sd1 <<< (BASIS_FRAC - 1));
         r = v[63:BASIS_FRAC];
         if (r > 37'sd2147483647) begin
            lane_out[c] = 32'sh7FFF_FFFF;
         end else if (r < -37'sd2147483648) begin
            lane_out[c] = 32'sh8000_0000;
         end else begin
            lane_out[c] = r[31:0];
         end
      end
   end

   always_comb begin
      rsp_item.point_x        = lane_out[0];
      rsp_item.point_y        = lane_out[1];
      rsp_item.point_z        = lane_out[2];
      rsp_item.too_few_points = too_few_ff;
   end

endmodule
`default_nettype wire

/* rtl/bspe_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// B-spline evaluator controller
// Walks the basis triangle term by term, then the weighted point sum.
// ----------------------------------------------------------------------------
module bspe_ctrl import bspe_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             opcode,
   input  logic [DEG_W-1:0] degree,
   input  bspe_status_type  status,
   output logic             busy,
   output logic             rsp_valid,
   output bspe_cmd_type     cmd
);

   bspe_state_type   state_ff, state_in;
   logic [DEG_W-1:0] k_ff, k_in;
   logic [DEG_W-1:0] j_ff, j_in;
   logic             term_ff, term_in;
   logic             accept;

   assign accept = start && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         j_ff     <= '0;
         term_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         j_ff     <= j_in;
         term_ff  <= term_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      term_in  = term_ff;
      cmd      = '0;
      cmd.k    = k_ff;
      cmd.j    = j_ff;
      cmd.term = term_ff;
      busy      = (state_ff != ST_IDLE);
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (opcode == OP_WRITE) begin
                  cmd.write_point = 1'b1;
               end else begin
                  cmd.load_t = 1'b1;
                  state_in   = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            if (status.too_few || !status.span_ok) begin
               state_in = ST_DONE;
            end else begin
               k_in     = DEG_W'(1);
               j_in     = degree - DEG_W'(1);
               term_in  = 1'b0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (status.div_done) begin
               cmd.take = 1'b1;
               state_in = ST_MUL;
               if (!term_ff) begin
                  term_in = 1'b1;
               end else begin
                  term_in = 1'b0;
                  if (j_ff == degree) begin
                     if (k_ff == degree) begin
                        j_in     = '0;
                        state_in = ST_SUM_READ;
                     end else begin
                        k_in = k_ff + DEG_W'(1);
                        j_in = degree - k_ff - DEG_W'(1);
                     end
                  end else begin
                     j_in = j_ff + DEG_W'(1);
                  end
               end
            end
         end
         ST_SUM_READ: begin
            cmd.sum_read = 1'b1;
            state_in     = ST_SUM_MUL;
         end
         ST_SUM_MUL: begin
            cmd.sum_mul = 1'b1;
            state_in    = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            cmd.sum_acc = 1'b1;
            if (j_ff == degree) begin
               state_in = ST_DONE;
            end else begin
               j_in     = j_ff + DEG_W'(1);
               state_in = ST_SUM_READ;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // A result strobe lasts a single cycle.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // An accepted evaluate request makes the block busy next cycle.
   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && opcode == OP_EVAL) |=> busy)
      else $error("evaluate request did not start the sequence");

   // A write request never produces a result in the next cycle.
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && opcode == OP_WRITE) |=> !rsp_valid && !busy)
      else $error("write request disturbed the sequencer");

   // Divider results are taken only while waiting for them.
   a_take_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> (state_ff == ST_DIV_WAIT) && status.div_done)
      else $error("term taken without a divider result");

endmodule
`default_nettype wire

/* rtl/bspline_point_evaluator.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// B-spline point evaluator
// Stores 3D control points and evaluates a uniform or clamped B-spline.
// ----------------------------------------------------------------------------
// A write request stores one control point and never raises busy. An evaluate
// request raises busy, walks the basis triangle and the point sum, and drives
// its result for exactly one cycle with rsp_valid; there is no back-pressure,
// so the receiver must take it then. Each of the basis triangle's d*(d+3)
// terms goes through one shared multiplier and a long divider that resolves
// eight quotient bits a cycle, and the final sum reads one control point at a
// time from the point memory. Too few points or a parameter outside every knot
// span skips straight from setup to the result. The user must write
// configuration through the csr port only while the block is idle; the block
// itself does not enforce this.
module bspline_point_evaluator import bspe_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  bspe_req_type          req_item,
   output logic                  rsp_valid,
   output bspe_rsp_type          rsp_item,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [DEG_W-1:0] degree_ff;
   logic             clamped_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_eff;
   bspe_cmd_type     cmd;
   bspe_status_type  status;

   assign csr_ready = 1'b1;

   // Configuration registers; a zero degree write is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff  <= DEG_W'(3);
         clamped_ff <= 1'b0;
         count_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEGREE: begin
               if (csr_data[DEG_W-1:0] != '0) begin
                  degree_ff <= csr_data[DEG_W-1:0];
               end
            end
            CSR_CLAMPED: begin
               clamped_ff <= csr_data[0];
            end
            CSR_COUNT: begin
               count_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Point count in use, limited to the store size.
   assign count_eff = (count_ff > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_ff;

   bspe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .opcode    (req_item.opcode),
      .degree    (degree_ff),
      .status    (status),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   bspe_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .degree    (degree_ff),
      .clamped   (clamped_ff),
      .count_eff (count_eff),
      .req_item  (req_item),
      .status    (status),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

/* tb/sv/bspline_point_evaluator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// B-spline point evaluator testbench
// Drives control point writes and curve evaluations through the command
// port, changes the knot setup between phases, and checks every curve point
// against a fixed-point Cox-de Boor predictor kept inside the bench.
// ----------------------------------------------------------------------------
module bspline_point_evaluator_tb import bspe_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 700;
   localparam longint Q16_ONE    = 65536;
   localparam longint UNIT_BASIS = longint'(1) << BASIS_FRAC;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   bspe_req_type          req_item;
   logic                  rsp_valid;
   bspe_rsp_type          rsp_item;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Predictor state: the point store and the knot setup.
   longint        point_store [MAX_POINTS][3];
   int unsigned   cur_degree;
   int unsigned   cur_clamped;
   int unsigned   cur_count;

   bspe_rsp_type  pending_points [$];
   int            mismatch_count;
   int            idle_cycles;

   bspline_point_evaluator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Knot value for knot slot j at degree d with n points in use.
   function automatic longint knot_at_slot(longint j, longint d, longint n);
      longint v;
      v = j - d;
      if (cur_clamped != 0) begin
         if (v < 0) v = 0;
         if (v > n - d) v = n - d;
      end
      return v;
   endfunction

   // One weighted term of the basis recursion, rounded half up.
   function automatic longint weigh_term(longint num, longint b, longint den);
      longint q;
      if (b == 0 || num <= 0 || den <= 0) return 0;
      q = den << 16;
      return (num * b + q / 2) / q;
   endfunction

   function automatic logic signed [31:0] round_to_q16(longint v);
      longint r;
      r = (v + (longint'(1) << (BASIS_FRAC - 1))) >>> BASIS_FRAC;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[31:0];
   endfunction

   // Curve point at the request's parameter under the current setup.
   function automatic bspe_rsp_type curve_point(bspe_req_type r);
      bspe_rsp_type res;
      longint basis [MAX_POINTS + MAX_DEGREE + 1];
      longint acc [3];
      longint n, d, t, span, lo, hi, ui, uik, ui1, uik1, s;
      res = '0;
      n = (cur_count > MAX_POINTS) ? MAX_POINTS : cur_count;
      d = cur_degree;
      if (n < d + 1) begin
         res.too_few_points = 1'b1;
         return res;
      end
      t = r.param_t;
      span = n + d;
      for (int i = 0; i < span; i++) begin
         lo = knot_at_slot(i, d, n) * Q16_ONE;
         hi = knot_at_slot(i + 1, d, n) * Q16_ONE;
         basis[i] = (lo <= t && t < hi) ? UNIT_BASIS : 0;
      end
      for (int k = 1; k <= d; k++) begin
         for (int i = 0; i < span - k; i++) begin
            ui   = knot_at_slot(i, d, n);
            uik  = knot_at_slot(i + k, d, n);
            ui1  = knot_at_slot(i + 1, d, n);
            uik1 = knot_at_slot(i + k + 1, d, n);
            s = 0;
            if (uik != ui) s += weigh_term(t - ui * Q16_ONE, basis[i], uik - ui);
            if (uik1 != ui1)
               s += weigh_term(uik1 * Q16_ONE - t, basis[i + 1], uik1 - ui1);
            basis[i] = (s > UNIT_BASIS) ? UNIT_BASIS : s;
         end
      end
      for (int c = 0; c < 3; c++) acc[c] = 0;
      for (int i = 0; i < n; i++) begin
         if (basis[i] != 0) begin
            for (int c = 0; c < 3; c++) acc[c] += basis[i] * point_store[i][c];
         end
      end
      res.point_x = round_to_q16(acc[0]);
      res.point_y = round_to_q16(acc[1]);
      res.point_z = round_to_q16(acc[2]);
      return res;
   endfunction

   // Gap length: mostly none, sometimes short, rarely long.
   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(99);
      if (sel < 65) return 0;
      if (sel < 95) return $urandom_range(3, 1);
      return $urandom_range(60, 20);
   endfunction

   // Send one request, update the predictor on acceptance.
   task automatic send_request(input bspe_req_type r);
      int gap;
      req_item <= r;
      start    <= 1'b1;
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
      if (r.opcode == OP_WRITE) begin
         point_store[r.point_index][0] = r.coord_x;
         point_store[r.point_index][1] = r.coord_y;
         point_store[r.point_index][2] = r.coord_z;
      end else begin
         pending_points = {pending_points, curve_point(r)};
      end
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Wait until every curve point has come back and the block is idle.
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_points.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      while (busy) @(negedge clock);
      @(posedge clock);
   endtask

   // Write one register; the caller drops csr_valid after the last write.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      @(negedge clock);
      while (!csr_ready) @(negedge clock);
      @(posedge clock);
      if (idx == CSR_DEGREE) begin
         if (value[2:0] != 0)
            cur_degree = (value[2:0] > MAX_DEGREE) ? MAX_DEGREE : value[2:0];
      end else if (idx == CSR_CLAMPED) begin
         cur_clamped = value[0];
      end else if (idx == CSR_COUNT) begin
         cur_count = value;
      end
   endtask

   task automatic set_curve(input int d, input int cl, input int cnt);
      wait_idle();
      write_register(CSR_DEGREE, {4'($urandom), 3'(d)});
      write_register(CSR_CLAMPED, {6'($urandom), 1'(cl)});
      write_register(CSR_COUNT, 7'(cnt));
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [31:0] random_coord();
      if ($urandom_range(1) == 0) return $urandom;
      return $signed($urandom_range(200 * 65536)) - 100 * 65536;
   endfunction

   task automatic write_point(input int slot, input logic signed [31:0] x,
                              input logic signed [31:0] y, input logic signed [31:0] z);
      bspe_req_type r;
      r = '0;
      r.opcode      = OP_WRITE;
      r.point_index = 6'(slot);
      r.coord_x     = x;
      r.coord_y     = y;
      r.coord_z     = z;
      r.param_t     = 24'($urandom);
      send_request(r);
   endtask

   task automatic eval_at(input logic signed [23:0] t);
      bspe_req_type r;
      r = '0;
      r.opcode      = OP_EVAL;
      r.point_index = 6'($urandom);
      r.coord_x     = $urandom;
      r.coord_y     = $urandom;
      r.coord_z     = $urandom;
      r.param_t     = t;
      send_request(r);
   endtask

   // Directed: extreme coordinates and parameters, knot ends, odd settings.
   task automatic test_directed();
      for (int i = 0; i < MAX_POINTS; i++) write_point(i, random_coord(), random_coord(),
                                                      random_coord());
      write_point(0, 32'h7fffffff, 32'h80000000, 32'h0);
      write_point(1, 32'h7fffffff, 32'h80000000, 32'hffffffff);
      write_point(2, 32'h7fffffff, 32'h80000000, 32'h00010000);
      write_point(3, 32'h7fffffff, 32'h80000000, 32'h00010000);
      // Count still zero after reset: too few points.
      eval_at(24'sd0);
      set_curve(3, 0, 4);
      eval_at(24'sd0);
      eval_at(-24'sd8388608);
      eval_at(24'sd8388607);
      eval_at(24'sh010000);
      // A degree write of zero is ignored.
      set_curve(0, 1, 4);
      eval_at(24'sh000000);
      eval_at(24'sh008000);
      // Clamped end knot gives zero.
      eval_at(24'sh010000);
      set_curve(7, 1, 7);
      eval_at(24'sd0);
      set_curve(7, 1, 8);
      eval_at(24'sh00c000);
      set_curve(1, 0, 127);
      eval_at(24'sh3f0000);
      eval_at(24'sh400000);
      set_curve(7, 0, 64);
      eval_at(24'sh200000);
      eval_at(-24'sh070000);
   endtask

   // Random: varied setups, also too few points and counts beyond the store, parameters mostly inside the knot range.
   task automatic test_random(input int phases, input int per_phase);
      int d, cl, cnt, sel, n;
      logic signed [23:0] t;
      for (int p = 0; p < phases; p++) begin
         d  = $urandom_range(MAX_DEGREE, 1);
         cl = $urandom_range(1);
         sel = $urandom_range(9);
         if (sel == 0) cnt = $urandom_range(d);
         else if (sel == 1) cnt = $urandom_range(127, 64);
         else if (sel < 4) cnt = d + 1;
         else cnt = $urandom_range(16, d + 1);
         if (p == 0) begin
            d = MAX_DEGREE; cnt = MAX_POINTS;
         end
         set_curve(d, cl, cnt);
         n = (cnt > MAX_POINTS) ? MAX_POINTS : cnt;
         for (int i = 0; i < per_phase; i++) begin
            sel = $urandom_range(99);
            if (sel < 30) begin
               write_point($urandom_range(MAX_POINTS - 1), random_coord(), random_coord(),
                           random_coord());
            end else begin
               if (sel < 75)
                  t = 24'($signed($urandom_range((n + d + 2) * 65536)) - (d + 1) * 65536);
               else if (sel < 88)
                  t = 24'(($signed($urandom_range(n + d + 2)) - d - 1) * 65536);
               else
                  t = 24'($urandom);
               eval_at(t);
            end
         end
      end
   endtask

   // Result checker.
   always @(posedge clock) begin
      bspe_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_points.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected curve point %h", rsp_item);
         end else begin
            want = pending_points.pop_front();
            if (rsp_item.point_x !== want.point_x || rsp_item.point_y !== want.point_y ||
                rsp_item.point_z !== want.point_z ||
                rsp_item.too_few_points !== want.too_few_points) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("curve point mismatch: expected %h got %h", want, rsp_item);
            end
         end
      end
   end

   // Watchdog on cycles in which no handshake completes.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      mismatch_count = 0;
      idle_cycles    = 0;
      cur_degree     = 3;
      cur_clamped    = 0;
      cur_count      = 0;
      for (int i = 0; i < MAX_POINTS; i++)
         for (int c = 0; c < 3; c++) point_store[i][c] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(16, 30);
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_points.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
